/* src/icsp_pkg.sv */
// shared constants, command codes and controller/datapath interface types
package icsp_pkg;

    localparam int unsigned WORD_W = 14;
    localparam int unsigned PC_W   = 16;

    localparam logic [WORD_W-1:0] BLANK_WORD = 14'h3FFF;
    localparam logic [PC_W-1:0]   CFG_BASE   = 16'h8000;
    localparam logic [PC_W-1:0]   ID_ADDR    = 16'h8006;
    localparam logic [PC_W-1:0]   CW1_ADDR   = 16'h8007;
    localparam logic [PC_W-1:0]   CW2_ADDR   = 16'h8008;

    // command codes
    localparam logic [2:0] MODE_LOAD_CFG   = 3'd0;
    localparam logic [2:0] MODE_LOAD_LATCH = 3'd1;
    localparam logic [2:0] MODE_READ       = 3'd2;
    localparam logic [2:0] MODE_INC_PC     = 3'd3;
    localparam logic [2:0] MODE_RESET_PC   = 3'd4;
    localparam logic [2:0] MODE_PROGRAM    = 3'd5;
    localparam logic [2:0] MODE_ERASE      = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_DEVICE_ID = 2'd0;
    localparam logic [1:0] REG_REVISION  = 2'd1;
    localparam logic [1:0] REG_CODE_SIZE = 2'd2;
    localparam logic [1:0] REG_CW2_MASK  = 2'd3;

    localparam int unsigned CFG_DATA_W = 15;

    typedef struct packed {
        logic pc_cfg;
        logic pc_inc;
        logic pc_clr;
        logic latch_wr;
        logic latch_blank;
        logic mem_rd;
        logic row_start;
        logic row_step;
        logic cfg_rd;
        logic cfg_commit;
        logic sweep_start;
        logic sweep_step;
        logic out_load;
    } icsp_cmd_t;

    typedef struct packed {
        logic pc_in_code;
        logic row_done;
        logic sweep_done;
        logic out_busy;
    } icsp_status_t;

endpackage

/* src/icsp_ctrl.sv */
// command sequencer for the programming port
module icsp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  icsp_pkg::icsp_status_t status,
    output icsp_pkg::icsp_cmd_t    cmd
);
    import icsp_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_ROW   = 6'b001000,
        S_CFGW  = 6'b010000,
        S_ERASE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_LOAD_CFG:   cmd.pc_cfg = 1'b1;
                        MODE_LOAD_LATCH: cmd.latch_wr = 1'b1;
                        MODE_READ:
                        begin
                            cmd.mem_rd = 1'b1;
                            state_next = S_READ;
                        end
                        MODE_INC_PC:     cmd.pc_inc = 1'b1;
                        MODE_RESET_PC:   cmd.pc_clr = 1'b1;
                        MODE_PROGRAM:
                        begin
                            if (status.pc_in_code)
                            begin
                                cmd.row_start = 1'b1;
                                state_next    = S_ROW;
                            end
                            else
                            begin
                                cmd.cfg_rd = 1'b1;
                                state_next = S_CFGW;
                            end
                        end
                        MODE_ERASE:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = S_ERASE;
                        end
                        default: ;
                    endcase
                end
            end
            S_READ:
            begin
                // wait for the output register to free up
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ROW:
            begin
                cmd.row_step = 1'b1;
                if (status.row_done)
                begin
                    cmd.latch_blank = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_CFGW:
            begin
                cmd.cfg_commit  = 1'b1;
                cmd.latch_blank = 1'b1;
                state_next      = S_IDLE;
            end
            S_ERASE:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* src/icsp_dp.sv */
// program counter, row latches, program memory, config words and output register
module icsp_dp #(
    parameter int unsigned MEM_WORDS = 16384,
    parameter int unsigned ROW_WORDS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  icsp_pkg::icsp_cmd_t               cmd,
    output icsp_pkg::icsp_status_t            status,
    input  logic [icsp_pkg::WORD_W-1:0]       data_word,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [icsp_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [icsp_pkg::WORD_W-1:0]       read_word
);
    import icsp_pkg::*;

    localparam int unsigned AW  = $clog2(MEM_WORDS);
    localparam int unsigned SW  = $clog2(ROW_WORDS);
    localparam int unsigned RCW = $clog2(ROW_WORDS + 1);
    localparam int unsigned CCW = $clog2(MEM_WORDS + 1);
    localparam logic [PC_W-1:0] MEM_LIM  = PC_W'(MEM_WORDS);
    localparam logic [SW-1:0]   CFG_SLOT = SW'(32768 % ROW_WORDS);
    localparam logic [SW-1:0]   LAST_SLOT = SW'(ROW_WORDS - 1);
    localparam logic [RCW-1:0]  ROW_END = RCW'(ROW_WORDS);
    localparam logic [CCW-1:0]  SWEEP_LAST = CCW'(MEM_WORDS - 1);

    // configuration registers
    logic [8:0]        device_id_reg;
    logic [4:0]        revision_reg;
    logic [14:0]       code_size_reg;
    logic [WORD_W-1:0] mask_two_reg;

    logic [PC_W-1:0]   pc_reg;
    logic [SW-1:0]     slot_reg;
    logic [WORD_W-1:0] cw1_reg;
    logic [WORD_W-1:0] cw2_reg;

    logic [WORD_W-1:0] latch_mem [ROW_WORDS];
    logic [ROW_WORDS-1:0] latch_vld_reg;
    logic [WORD_W-1:0] latch_rdata_reg;
    logic              latch_rvld_reg;
    logic              latch_re;
    logic [SW-1:0]     latch_raddr;
    logic [WORD_W-1:0] latch_word;

    logic [WORD_W-1:0] prog_mem [MEM_WORDS];
    logic [WORD_W-1:0] mem_rdata_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    logic [RCW-1:0]    row_cnt_reg;
    logic              row_wv_reg;
    logic              row_wok_reg;
    logic [AW-1:0]     row_waddr_reg;
    logic [CCW-1:0]    clr_cnt_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] read_word_reg;

    logic [PC_W-1:0]   used_words;
    logic              pc_in_code;
    logic [PC_W-1:0]   row_base;
    logic [PC_W:0]     row_addr;
    logic              row_issue;
    logic [WORD_W-1:0] rd_value;

    assign used_words = ({1'b0, code_size_reg} < MEM_LIM) ? {1'b0, code_size_reg} : MEM_LIM;
    assign pc_in_code = pc_reg < used_words;
    assign row_base   = pc_reg - PC_W'(slot_reg);
    assign row_addr   = {1'b0, row_base} + (PC_W + 1)'(row_cnt_reg);
    assign row_issue  = cmd.row_step && (row_cnt_reg < ROW_END);

    assign status.pc_in_code = pc_in_code;
    assign status.row_done   = (row_cnt_reg == ROW_END);
    assign status.sweep_done = (clr_cnt_reg == SWEEP_LAST);
    assign status.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign read_word = read_word_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_id_reg <= '0;
            revision_reg  <= '0;
            code_size_reg <= 15'd16384;
            mask_two_reg  <= BLANK_WORD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEVICE_ID: device_id_reg <= cfg_data[8:0];
                REG_REVISION:  revision_reg  <= cfg_data[4:0];
                REG_CODE_SIZE: code_size_reg <= cfg_data;
                REG_CW2_MASK:  mask_two_reg  <= cfg_data[WORD_W-1:0];
                default: ;
            endcase
        end
    end

    // program counter with its slot in the row kept alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            slot_reg <= '0;
        end
        else if (cmd.pc_cfg)
        begin
            pc_reg   <= CFG_BASE;
            slot_reg <= CFG_SLOT;
        end
        else if (cmd.pc_clr)
        begin
            pc_reg   <= '0;
            slot_reg <= '0;
        end
        else if (cmd.pc_inc)
        begin
            pc_reg <= pc_reg + 1'b1;
            if (slot_reg == LAST_SLOT || pc_reg == '1)
            begin
                slot_reg <= '0;
            end
            else
            begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // row latches: storage plus per-entry valid, invalid reads as blank
    assign latch_re    = row_issue || cmd.cfg_rd;
    assign latch_raddr = cmd.cfg_rd ? slot_reg : row_cnt_reg[SW-1:0];
    assign latch_word  = latch_rvld_reg ? latch_rdata_reg : BLANK_WORD;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_wr)
        begin
            latch_mem[slot_reg] <= data_word;
        end
        if (latch_re)
        begin
            latch_rdata_reg <= latch_mem[latch_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_vld_reg  <= '0;
            latch_rvld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch_blank)
            begin
                latch_vld_reg <= '0;
            end
            else if (cmd.latch_wr)
            begin
                latch_vld_reg[slot_reg] <= 1'b1;
            end
            if (latch_re)
            begin
                latch_rvld_reg <= latch_vld_reg[latch_raddr];
            end
        end
    end

    // row programming pipeline: latch read, then memory write in the following cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            row_wv_reg  <= 1'b0;
        end
        else if (cmd.row_start)
        begin
            row_cnt_reg <= '0;
            row_wv_reg  <= 1'b0;
        end
        else if (cmd.row_step)
        begin
            row_wv_reg <= row_issue;
            if (row_issue)
            begin
                row_cnt_reg <= row_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_issue)
        begin
            row_waddr_reg <= row_addr[AW-1:0];
            row_wok_reg   <= row_addr < {1'b0, used_words};
        end
    end

    // clearing sweep after reset and on bulk erase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.sweep_start)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // configuration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw1_reg <= BLANK_WORD;
            cw2_reg <= BLANK_WORD;
        end
        else if (cmd.sweep_start)
        begin
            cw1_reg <= BLANK_WORD;
            cw2_reg <= BLANK_WORD;
        end
        else if (cmd.cfg_commit)
        begin
            if (pc_reg == CW1_ADDR)
            begin
                cw1_reg <= latch_word;
            end
            else if (pc_reg == CW2_ADDR)
            begin
                cw2_reg <= latch_word;
            end
        end
    end

    // program memory, single write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg[AW-1:0];
        mem_wdata = BLANK_WORD;
        if (cmd.sweep_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.row_step && row_wv_reg && row_wok_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = row_waddr_reg;
            mem_wdata = latch_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prog_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd && pc_in_code)
        begin
            mem_rdata_reg <= prog_mem[pc_reg[AW-1:0]];
        end
    end

    // read value at the counter
    always_comb
    begin
        if (pc_in_code)
        begin
            rd_value = mem_rdata_reg;
        end
        else
        begin
            case (pc_reg)
                ID_ADDR:  rd_value = {device_id_reg, revision_reg};
                CW1_ADDR: rd_value = cw1_reg;
                CW2_ADDR: rd_value = cw2_reg & mask_two_reg;
                default:  rd_value = BLANK_WORD;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            read_word_reg <= rd_value;
        end
    end

endmodule

/* src/icsp_flash_programming_target_unit.sv */
// top level of the flash programming port target
// loads, counter commands and unused codes finish in the accepting state; a read passes
// through S_READ, which waits for the output register to free up before loading it; row
// programming writes one latch word per cycle; config word programming goes through S_CFGW;
// bulk erase makes one memory write per cycle. after reset a clearing pass blanks the
// program memory before the first item is taken; config writes are taken at any time
module icsp_flash_programming_target_unit #(
    parameter int unsigned MEM_WORDS = 16384,
    parameter int unsigned ROW_WORDS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [2:0]                      mode,
    input  logic [icsp_pkg::WORD_W-1:0]     data_word,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [icsp_pkg::WORD_W-1:0]     read_word,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [icsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import icsp_pkg::*;

    icsp_cmd_t    cmd;
    icsp_status_t status;

    assign cfg_ready = 1'b1;

    icsp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    icsp_dp #(
        .MEM_WORDS (MEM_WORDS),
        .ROW_WORDS (ROW_WORDS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .data_word (data_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_word (read_word)
    );

endmodule

/* tb/tb.sv */
// self-checking testbench for the flash programming port target unit
module tb;
    import icsp_pkg::*;

    localparam int unsigned MEM_WORDS     = 16384;
    localparam int unsigned ROW_WORDS     = 32;
    localparam logic [2:0]  MODE_UNUSED   = 3'd7;
    // long enough for a bulk erase or a row program still running after the last read
    localparam int          SETTLE_CYCLES = MEM_WORDS + 2 * ROW_WORDS;
    // clearing pass, a few dozen erases and every item at its longest idles, many times over
    localparam int          CYCLE_LIMIT   = 6000000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            mode = '0;
    logic [WORD_W-1:0]     data_word = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [WORD_W-1:0]     read_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [1:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit quiet = 1'b0;
    int long_hold = 0;
    int commands_sent = 0;
    int reg_writes = 0;
    int cycle_count = 0;

    // tracks the target's counter, latches, memory and config words
    class flash_mirror;
        logic [PC_W-1:0]   pc;
        logic [WORD_W-1:0] latch [ROW_WORDS];
        logic [WORD_W-1:0] mem [MEM_WORDS];
        logic [WORD_W-1:0] cw1;
        logic [WORD_W-1:0] cw2;
        logic [8:0]        dev_id;
        logic [4:0]        rev;
        logic [14:0]       code_size;
        logic [WORD_W-1:0] word_two_mask;
        logic [WORD_W-1:0] pending_reads [$];
        int                errors;
        int                reads_checked;
        int                erases;

        function new();
            pc = '0;
            foreach (latch[i]) latch[i] = BLANK_WORD;
            foreach (mem[i]) mem[i] = BLANK_WORD;
            cw1 = BLANK_WORD;
            cw2 = BLANK_WORD;
            dev_id = '0;
            rev = '0;
            code_size = 15'd16384;
            word_two_mask = BLANK_WORD;
            errors = 0;
            reads_checked = 0;
            erases = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_DEVICE_ID: dev_id = val[8:0];
                REG_REVISION:  rev = val[4:0];
                REG_CODE_SIZE: code_size = val[14:0];
                REG_CW2_MASK:  word_two_mask = val[WORD_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_command(logic [2:0] m, logic [WORD_W-1:0] d);
            int unsigned lim;
            int unsigned slot;
            int unsigned base;
            logic [WORD_W-1:0] w;
            lim = (code_size < MEM_WORDS) ? code_size : MEM_WORDS;
            slot = pc % ROW_WORDS;
            case (m)
                MODE_LOAD_CFG:   pc = CFG_BASE;
                MODE_LOAD_LATCH: latch[slot] = d;
                MODE_READ:
                begin
                    if (pc < lim)
                        w = mem[pc];
                    else if (pc == ID_ADDR)
                        w = {dev_id, rev};
                    else if (pc == CW1_ADDR)
                        w = cw1;
                    else if (pc == CW2_ADDR)
                        w = cw2 & word_two_mask;
                    else
                        w = BLANK_WORD;
                    pending_reads.push_back(w);
                end
                MODE_INC_PC:     pc = pc + 1'b1;
                MODE_RESET_PC:   pc = '0;
                MODE_PROGRAM:
                begin
                    if (pc < lim)
                    begin
                        base = pc - slot;
                        // row may straddle the end of the code region
                        for (int i = 0; i < ROW_WORDS; i++)
                            if (base + i < lim)
                                mem[base + i] = latch[i];
                    end
                    else if (pc == CW1_ADDR)
                        cw1 = latch[slot];
                    else if (pc == CW2_ADDR)
                        cw2 = latch[slot];
                    foreach (latch[i]) latch[i] = BLANK_WORD;
                end
                MODE_ERASE:
                begin
                    foreach (mem[i]) mem[i] = BLANK_WORD;
                    cw1 = BLANK_WORD;
                    cw2 = BLANK_WORD;
                    erases++;
                end
                default: ;
            endcase
        endfunction

        function void check_read(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (pending_reads.size() == 0)
            begin
                $error("read_word: no item expected, got %h", got);
                errors++;
                return;
            end
            want = pending_reads.pop_front();
            reads_checked++;
            if (got !== want)
            begin
                $error("read_word mismatch: expected %h, got %h", want, got);
                errors++;
            end
        endfunction
    endclass

    flash_mirror flash = new();

    icsp_flash_programming_target_unit #(
        .MEM_WORDS (MEM_WORDS),
        .ROW_WORDS (ROW_WORDS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .data_word (data_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_word (read_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // result side: random stall per item, plus one long hold on request
    initial
    begin
        int stall;
        forever
        begin
            if (long_hold != 0)
            begin
                stall = long_hold;
                long_hold = 0;
            end
            else if (quiet)
                stall = 0;
            else
                stall = $urandom_range(0, 17);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            flash.check_read(read_word);
        end
    end

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return BLANK_WORD;
            default: return WORD_W'($urandom_range(0, 16383));
        endcase
    endfunction

    task automatic push_item(input logic [2:0] m, input logic [WORD_W-1:0] d);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        data_word <= d;
        do @(posedge clk); while (!in_ready);
        flash.take_command(m, d);
        if (m != MODE_UNUSED)
            commands_sent++;
    endtask

    task automatic step_pc(input int n);
        repeat (n) push_item(MODE_INC_PC, pick_word());
    endtask

    // sender stops until every read has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (flash.pending_reads.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        flash.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic write_regs(input int id, input int rev, input int size, input int mask);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_DEVICE_ID, CFG_DATA_W'(id));
        write_reg(REG_REVISION, CFG_DATA_W'(rev));
        write_reg(REG_CODE_SIZE, CFG_DATA_W'(size));
        write_reg(REG_CW2_MASK, CFG_DATA_W'(mask));
    endtask

    task automatic random_part(input int n);
        int stop_at;
        int kind;
        logic [2:0] m;
        stop_at = commands_sent + n;
        while (commands_sent < stop_at)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 2)
                push_item(MODE_ERASE, pick_word());
            else if (kind < 40)
            begin
                // fill some latches around a random spot and burn the row
                if ($urandom_range(0, 2) == 0 || flash.pc > 200)
                    push_item(MODE_RESET_PC, pick_word());
                step_pc($urandom_range(0, 40));
                repeat ($urandom_range(1, 6))
                begin
                    push_item(MODE_LOAD_LATCH, pick_word());
                    if ($urandom_range(0, 1) == 1)
                        step_pc($urandom_range(1, 3));
                end
                if ($urandom_range(0, 4) != 0)
                    push_item(MODE_PROGRAM, pick_word());
            end
            else if (kind < 60)
            begin
                if ($urandom_range(0, 3) == 0 || flash.pc > 200)
                    push_item(MODE_RESET_PC, pick_word());
                repeat ($urandom_range(1, 8))
                begin
                    push_item(MODE_READ, pick_word());
                    if ($urandom_range(0, 2) != 0)
                        step_pc($urandom_range(1, 4));
                end
            end
            else if (kind < 80)
            begin
                // mostly land on the id and config words
                push_item(MODE_LOAD_CFG, pick_word());
                step_pc(($urandom_range(0, 3) != 0) ? $urandom_range(6, 8)
                                                    : $urandom_range(0, 12));
                if ($urandom_range(0, 1) == 1)
                    push_item(MODE_LOAD_LATCH, pick_word());
                if ($urandom_range(0, 1) == 1)
                    push_item(MODE_PROGRAM, pick_word());
                push_item(MODE_READ, pick_word());
                if ($urandom_range(0, 1) == 1)
                begin
                    push_item(MODE_INC_PC, pick_word());
                    push_item(MODE_READ, pick_word());
                end
            end
            else if (kind < 96)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    m = 3'($urandom_range(0, 7));
                    if (m == MODE_ERASE)
                        m = MODE_READ;
                    push_item(m, pick_word());
                end
            end
            else
                drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // short code region so the second row is only partly in use
        write_regs(9'h1A5, 5'h13, 40, 14'h2AAA);
        push_item(MODE_READ, 14'h0000);
        push_item(MODE_LOAD_LATCH, 14'h0000);
        push_item(MODE_INC_PC, BLANK_WORD);
        push_item(MODE_LOAD_LATCH, 14'h2AAA);
        push_item(MODE_PROGRAM, BLANK_WORD);
        push_item(MODE_RESET_PC, BLANK_WORD);
        push_item(MODE_INC_PC, 14'h0000);
        push_item(MODE_READ, BLANK_WORD);
        push_item(MODE_UNUSED, BLANK_WORD);
        push_item(MODE_LOAD_CFG, BLANK_WORD);
        step_pc(6);
        push_item(MODE_READ, 14'h1555);
        push_item(MODE_INC_PC, 14'h0000);
        push_item(MODE_LOAD_LATCH, 14'h0F0F);
        push_item(MODE_PROGRAM, 14'h0000);
        push_item(MODE_READ, 14'h0000);
        push_item(MODE_INC_PC, 14'h0000);
        push_item(MODE_LOAD_LATCH, 14'h3C3C);
        push_item(MODE_PROGRAM, 14'h0000);
        push_item(MODE_READ, 14'h0000);
        // past the config words nothing is written
        push_item(MODE_INC_PC, 14'h0000);
        push_item(MODE_LOAD_LATCH, 14'h1234);
        push_item(MODE_PROGRAM, 14'h0000);
        push_item(MODE_READ, 14'h0000);
        push_item(MODE_ERASE, BLANK_WORD);
        push_item(MODE_LOAD_CFG, 14'h0000);
        step_pc(7);
        push_item(MODE_READ, 14'h0000);
        push_item(MODE_RESET_PC, 14'h0000);
        push_item(MODE_INC_PC, 14'h0000);
        push_item(MODE_READ, 14'h0000);

        write_regs(511, 31, 16384, 16383);
        random_part(450);
        // stall the result side while reads keep coming so the input backs up
        drain();
        quiet = 1'b1;
        long_hold = 300;
        repeat (40) push_item(MODE_READ, pick_word());
        drain();
        quiet = 1'b0;

        write_regs(0, 0, 0, 0);
        random_part(300);

        // code size beyond the memory
        write_regs($urandom_range(0, 511), $urandom_range(0, 31), 32767,
                   $urandom_range(0, 16383));
        random_part(400);

        write_regs($urandom_range(0, 511), $urandom_range(0, 31), $urandom_range(1, 100),
                   $urandom_range(0, 16383));
        random_part(450);

        write_regs($urandom_range(0, 511), $urandom_range(0, 31), $urandom_range(33, 200),
                   $urandom_range(0, 16383));
        random_part(400);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d commands sent, %0d read words checked, %0d bulk erases",
                 commands_sent, flash.reads_checked, flash.erases);
        $display("%0d register writes over 6 settings, code sizes from zero past the memory",
                 reg_writes);
        if (flash.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
